// File: hdl/tloit_pkg.sv
// Shared types and constants for the two-list ordered id table.
`default_nettype none

package tloit_pkg;

    localparam int ID_COUNT_DEF = 64;
    localparam int SENTINELS    = 4;
    localparam int ID_W         = 8;
    localparam int SLOT_W       = 7;
    localparam int COUNT_W      = 7;

    // sentinel slots
    localparam logic [SLOT_W-1:0] HEAD_ATTR   = 7'd0;
    localparam logic [SLOT_W-1:0] TAIL_ATTR   = 7'd1;
    localparam logic [SLOT_W-1:0] HEAD_STYLE  = 7'd2;
    localparam logic [SLOT_W-1:0] TAIL_STYLE  = 7'd3;
    localparam logic [SLOT_W-1:0] FIRST_ENTRY = SLOT_W'(SENTINELS);

    // place codes
    localparam logic [1:0] PLACE_ATTR  = 2'd0;
    localparam logic [1:0] PLACE_STYLE = 2'd1;

    typedef enum logic {
        KIND_PUT  = 1'b0,
        KIND_WALK = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PLACE = 2'd1,
        ST_BAD_ID    = 2'd2
    } status_t;

    // one row of the link memory
    typedef struct packed {
        logic [SLOT_W-1:0] next;
        logic [SLOT_W-1:0] prev;
        logic              place;
        logic [ID_W-1:0]   key;
    } link_row_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEW_FIX,
        S_LOOK,
        S_ROW,
        S_MV_A,
        S_MV_A_WR,
        S_MV_B,
        S_MV_B_WR,
        S_MV_C,
        S_MV_C_WR,
        S_MV_D,
        S_WALK,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/tloit_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module tloit_ram #(
    parameter int WIDTH = tloit_pkg::SLOT_W,
    parameter int DEPTH = tloit_pkg::ID_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/two_list_ordered_id_table.sv
// Two-list ordered id table: ids kept in two insertion-ordered linked lists.
// A put or move updates each non-sentinel neighbor by read-modify-write on the link RAM port;
// a same-list put only looks up its slot.
// Walk: the first row is read from the link RAM, then one id per cycle unstalled.
// Next item is taken the cycle after the last result enters the output register.
// Async active-low reset clears control, counts, sentinels and presence bits; no RAM sweep.
`default_nettype none

module two_list_ordered_id_table #(
    parameter int ID_COUNT = tloit_pkg::ID_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [tloit_pkg::ID_W-1:0]    id,
    input  logic [1:0]                    place,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [tloit_pkg::SLOT_W-1:0]  slot,
    output logic                          created,
    output logic                          moved,
    output logic [tloit_pkg::COUNT_W-1:0] attr_count,
    output logic [tloit_pkg::COUNT_W-1:0] style_count,
    output logic [tloit_pkg::ID_W-1:0]    listed_id,
    output logic                          valid_res,
    output logic                          last
);

    import tloit_pkg::*;

    localparam int IW    = $clog2(ID_COUNT);
    localparam int ROW_W = $bits(link_row_t);

    // Entry slots start after the four sentinels; RAM row = slot - SENTINELS.
    function automatic logic [IW-1:0] row_of(input logic [SLOT_W-1:0] s);
        return IW'(s - FIRST_ENTRY);
    endfunction

    function automatic logic [SLOT_W-1:0] tail_of(input logic pl);
        return pl ? TAIL_STYLE : TAIL_ATTR;
    endfunction

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    // item being worked on
    logic              pl_reg, pl_next;        // target list: 0 attr, 1 style
    logic [ID_W-1:0]   id_reg, id_next;
    logic [SLOT_W-1:0] s_reg, s_next;          // entry slot
    logic [SLOT_W-1:0] p_reg, p_next;          // predecessor / append point
    logic [SLOT_W-1:0] n_reg, n_next;          // successor

    // result waiting for the output register
    status_t           pstat_reg, pstat_next;
    logic [SLOT_W-1:0] pslot_reg, pslot_next;
    logic              pcreated_reg, pcreated_next;
    logic              pmoved_reg, pmoved_next;

    // table-wide state
    logic [SLOT_W-1:0]  free_reg, free_next;
    logic [COUNT_W-1:0] attr_cnt_reg, attr_cnt_next;
    logic [COUNT_W-1:0] style_cnt_reg, style_cnt_next;

    // Sentinel links live in flops: head.next (first) and tail.prev (last)
    // of each list. head.prev and tail.next never change.
    logic [SLOT_W-1:0] attr_first_reg, attr_first_next;
    logic [SLOT_W-1:0] style_first_reg, style_first_next;
    logic [SLOT_W-1:0] attr_last_reg, attr_last_next;
    logic [SLOT_W-1:0] style_last_reg, style_last_next;

    // presence bit per id; the slot RAM entry is only read when set
    logic [ID_COUNT-1:0] present_reg;
    logic                present_set;
    logic [IW-1:0]       id_idx;

    // output register
    logic               out_valid_reg, out_valid_next;
    status_t            o_status_reg, o_status_next;
    logic [SLOT_W-1:0]  o_slot_reg, o_slot_next;
    logic               o_created_reg, o_created_next;
    logic               o_moved_reg, o_moved_next;
    logic [COUNT_W-1:0] o_attr_reg, o_attr_next;
    logic [COUNT_W-1:0] o_style_reg, o_style_next;
    logic [ID_W-1:0]    o_lid_reg, o_lid_next;
    logic               o_vres_reg, o_vres_next;
    logic               o_last_reg, o_last_next;
    logic               out_free;

    // RAM ports
    logic              sm_wr_en, sm_rd_en;
    logic [IW-1:0]     sm_wr_addr, sm_rd_addr;
    logic [SLOT_W-1:0] sm_wr_data, sm_rd_data;

    logic              lk_wr_en, lk_rd_en;
    logic [IW-1:0]     lk_wr_addr, lk_rd_addr;
    logic [ROW_W-1:0]  lk_rd_data;
    link_row_t         lk_wr_row, lk_rd_row;

    assign id_idx    = id[IW-1:0];
    assign lk_rd_row = lk_rd_data;

    // Output register frees up when empty or being drained this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // ---------------------------------------------------------------
    // Memories: id -> slot map, and link rows for entry slots
    // ---------------------------------------------------------------
    tloit_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ID_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (sm_wr_en),
        .wr_addr (sm_wr_addr),
        .wr_data (sm_wr_data),
        .rd_en   (sm_rd_en),
        .rd_addr (sm_rd_addr),
        .rd_data (sm_rd_data)
    );

    tloit_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ID_COUNT)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (lk_wr_en),
        .wr_addr (lk_wr_addr),
        .wr_data (lk_wr_row),
        .rd_en   (lk_rd_en),
        .rd_addr (lk_rd_addr),
        .rd_data (lk_rd_data)
    );

    // ---------------------------------------------------------------
    // Sequencer. Link fixups are read-modify-write on the link RAM;
    // rows touched by one item are always distinct, and every write of
    // an item lands before the next item's first read, so no forwarding.
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] tail_prev;
        link_row_t         row;

        cur       = pl_reg ? style_first_reg : attr_first_reg;
        tail_prev = pl_reg ? style_last_reg : attr_last_reg;
        row       = lk_rd_row;

        state_next       = state_reg;
        pl_next          = pl_reg;
        id_next          = id_reg;
        s_next           = s_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        pstat_next       = pstat_reg;
        pslot_next       = pslot_reg;
        pcreated_next    = pcreated_reg;
        pmoved_next      = pmoved_reg;
        free_next        = free_reg;
        attr_cnt_next    = attr_cnt_reg;
        style_cnt_next   = style_cnt_reg;
        attr_first_next  = attr_first_reg;
        style_first_next = style_first_reg;
        attr_last_next   = attr_last_reg;
        style_last_next  = style_last_reg;
        present_set      = 1'b0;

        sm_wr_en   = 1'b0;
        sm_wr_addr = id_idx;
        sm_wr_data = free_reg;
        sm_rd_en   = 1'b0;
        sm_rd_addr = id_idx;
        lk_wr_en   = 1'b0;
        lk_wr_addr = '0;
        lk_wr_row  = lk_rd_row;
        lk_rd_en   = 1'b0;
        lk_rd_addr = '0;

        o_status_next  = o_status_reg;
        o_slot_next    = o_slot_reg;
        o_created_next = o_created_reg;
        o_moved_next   = o_moved_reg;
        o_attr_next    = o_attr_reg;
        o_style_next   = o_style_reg;
        o_lid_next     = o_lid_reg;
        o_vres_next    = o_vres_reg;
        o_last_next    = o_last_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pl_next       = place[0];
                    id_next       = id;
                    pstat_next    = ST_OK;
                    pslot_next    = '0;
                    pcreated_next = 1'b0;
                    pmoved_next   = 1'b0;
                    cur       = place[0] ? style_first_reg : attr_first_reg;
                    tail_prev = place[0] ? style_last_reg : attr_last_reg;
                    if (place > PLACE_STYLE)
                    begin
                        // invalid place (deleted or bad code): checked ahead of everything else
                        pstat_next = ST_BAD_PLACE;
                        state_next = S_EMIT;
                    end
                    else if (kind == KIND_WALK)
                    begin
                        if (cur == tail_of(place[0]))
                        begin
                            // empty list: one result with valid_res low
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            lk_rd_en   = 1'b1;
                            lk_rd_addr = row_of(cur);
                            state_next = S_WALK;
                        end
                    end
                    else if (id >= ID_W'(ID_COUNT))
                    begin
                        pstat_next = ST_BAD_ID;
                        state_next = S_EMIT;
                    end
                    else if (!present_reg[id_idx])
                    begin
                        // new id: take the free slot and append at the tail
                        present_set     = 1'b1;
                        sm_wr_en        = 1'b1;
                        lk_wr_en        = 1'b1;
                        lk_wr_addr      = row_of(free_reg);
                        lk_wr_row.next  = tail_of(place[0]);
                        lk_wr_row.prev  = tail_prev;
                        lk_wr_row.place = place[0];
                        lk_wr_row.key   = id;
                        free_next       = free_reg + SLOT_W'(1);
                        s_next          = free_reg;
                        p_next          = tail_prev;
                        pslot_next      = free_reg;
                        pcreated_next   = 1'b1;
                        if (place[0])
                        begin
                            style_cnt_next  = style_cnt_reg + COUNT_W'(1);
                            style_last_next = free_reg;
                        end
                        else
                        begin
                            attr_cnt_next  = attr_cnt_reg + COUNT_W'(1);
                            attr_last_next = free_reg;
                        end
                        if (tail_prev < FIRST_ENTRY)
                        begin
                            // list was empty: head sentinel points at it
                            if (place[0])
                            begin
                                style_first_next = free_reg;
                            end
                            else
                            begin
                                attr_first_next = free_reg;
                            end
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            lk_rd_en   = 1'b1;
                            lk_rd_addr = row_of(tail_prev);
                            state_next = S_NEW_FIX;
                        end
                    end
                    else
                    begin
                        sm_rd_en   = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end

            S_NEW_FIX:
            begin
                // old tail entry now points at the new slot
                lk_wr_en       = 1'b1;
                lk_wr_addr     = row_of(p_reg);
                lk_wr_row.next = s_reg;
                state_next     = S_EMIT;
            end

            S_LOOK:
            begin
                s_next     = sm_rd_data;
                lk_rd_en   = 1'b1;
                lk_rd_addr = row_of(sm_rd_data);
                state_next = S_ROW;
            end

            S_ROW:
            begin
                pslot_next = s_reg;
                if (row.place == pl_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    p_next     = row.prev;
                    n_next     = row.next;
                    state_next = S_MV_A;
                end
            end

            // unlink: prev.next = next
            S_MV_A:
            begin
                if (p_reg < FIRST_ENTRY)
                begin
                    if (pl_reg)
                    begin
                        attr_first_next = n_reg;
                    end
                    else
                    begin
                        style_first_next = n_reg;
                    end
                    state_next = S_MV_B;
                end
                else
                begin
                    lk_rd_en   = 1'b1;
                    lk_rd_addr = row_of(p_reg);
                    state_next = S_MV_A_WR;
                end
            end

            S_MV_A_WR:
            begin
                lk_wr_en       = 1'b1;
                lk_wr_addr     = row_of(p_reg);
                lk_wr_row.next = n_reg;
                state_next     = S_MV_B;
            end

            // unlink: next.prev = prev
            S_MV_B:
            begin
                if (n_reg < FIRST_ENTRY)
                begin
                    if (pl_reg)
                    begin
                        attr_last_next = p_reg;
                    end
                    else
                    begin
                        style_last_next = p_reg;
                    end
                    state_next = S_MV_C;
                end
                else
                begin
                    lk_rd_en   = 1'b1;
                    lk_rd_addr = row_of(n_reg);
                    state_next = S_MV_B_WR;
                end
            end

            S_MV_B_WR:
            begin
                lk_wr_en       = 1'b1;
                lk_wr_addr     = row_of(n_reg);
                lk_wr_row.prev = p_reg;
                state_next     = S_MV_C;
            end

            // append: old tail of target list points at the entry
            S_MV_C:
            begin
                p_next = tail_prev;
                if (tail_prev < FIRST_ENTRY)
                begin
                    if (pl_reg)
                    begin
                        style_first_next = s_reg;
                    end
                    else
                    begin
                        attr_first_next = s_reg;
                    end
                    state_next = S_MV_D;
                end
                else
                begin
                    lk_rd_en   = 1'b1;
                    lk_rd_addr = row_of(tail_prev);
                    state_next = S_MV_C_WR;
                end
            end

            S_MV_C_WR:
            begin
                lk_wr_en       = 1'b1;
                lk_wr_addr     = row_of(p_reg);
                lk_wr_row.next = s_reg;
                state_next     = S_MV_D;
            end

            S_MV_D:
            begin
                lk_wr_en        = 1'b1;
                lk_wr_addr      = row_of(s_reg);
                lk_wr_row.next  = tail_of(pl_reg);
                lk_wr_row.prev  = p_reg;
                lk_wr_row.place = pl_reg;
                lk_wr_row.key   = id_reg;
                pmoved_next     = 1'b1;
                if (pl_reg)
                begin
                    style_last_next = s_reg;
                    style_cnt_next  = style_cnt_reg + COUNT_W'(1);
                    attr_cnt_next   = attr_cnt_reg - COUNT_W'(1);
                end
                else
                begin
                    attr_last_next = s_reg;
                    attr_cnt_next  = attr_cnt_reg + COUNT_W'(1);
                    style_cnt_next = style_cnt_reg - COUNT_W'(1);
                end
                state_next = S_EMIT;
            end

            S_WALK:
            begin
                // row of the current entry sits on the RAM output until used
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = ST_OK;
                    o_slot_next    = '0;
                    o_created_next = 1'b0;
                    o_moved_next   = 1'b0;
                    o_attr_next    = attr_cnt_reg;
                    o_style_next   = style_cnt_reg;
                    o_lid_next     = row.key;
                    o_vres_next    = 1'b1;
                    o_last_next    = (row.next == tail_of(pl_reg));
                    if (row.next == tail_of(pl_reg))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lk_rd_en   = 1'b1;
                        lk_rd_addr = row_of(row.next);
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = pstat_reg;
                    o_slot_next    = pslot_reg;
                    o_created_next = pcreated_reg;
                    o_moved_next   = pmoved_reg;
                    o_attr_next    = attr_cnt_reg;
                    o_style_next   = style_cnt_reg;
                    o_lid_next     = '0;
                    o_vres_next    = 1'b0;
                    o_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            free_reg        <= FIRST_ENTRY;
            attr_cnt_reg    <= '0;
            style_cnt_reg   <= '0;
            attr_first_reg  <= TAIL_ATTR;
            style_first_reg <= TAIL_STYLE;
            attr_last_reg   <= HEAD_ATTR;
            style_last_reg  <= HEAD_STYLE;
            present_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            free_reg        <= free_next;
            attr_cnt_reg    <= attr_cnt_next;
            style_cnt_reg   <= style_cnt_next;
            attr_first_reg  <= attr_first_next;
            style_first_reg <= style_first_next;
            attr_last_reg   <= attr_last_next;
            style_last_reg  <= style_last_next;
            if (present_set)
            begin
                present_reg[id_idx] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        pl_reg        <= pl_next;
        id_reg        <= id_next;
        s_reg         <= s_next;
        p_reg         <= p_next;
        n_reg         <= n_next;
        pstat_reg     <= pstat_next;
        pslot_reg     <= pslot_next;
        pcreated_reg  <= pcreated_next;
        pmoved_reg    <= pmoved_next;
        o_status_reg  <= o_status_next;
        o_slot_reg    <= o_slot_next;
        o_created_reg <= o_created_next;
        o_moved_reg   <= o_moved_next;
        o_attr_reg    <= o_attr_next;
        o_style_reg   <= o_style_next;
        o_lid_reg     <= o_lid_next;
        o_vres_reg    <= o_vres_next;
        o_last_reg    <= o_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = o_status_reg;
    assign slot        = o_slot_reg;
    assign created     = o_created_reg;
    assign moved       = o_moved_reg;
    assign attr_count  = o_attr_reg;
    assign style_count = o_style_reg;
    assign listed_id   = o_lid_reg;
    assign valid_res   = o_vres_reg;
    assign last        = o_last_reg;

endmodule

`default_nettype wire

// File: hdl/tloit_checker.sv
// Port-level assertions for the two-list ordered id table, with bind.
`default_nettype none

module tloit_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [tloit_pkg::SLOT_W-1:0]  slot,
    input logic                          created,
    input logic                          moved,
    input logic [tloit_pkg::COUNT_W-1:0] attr_count,
    input logic [tloit_pkg::COUNT_W-1:0] style_count,
    input logic [tloit_pkg::ID_W-1:0]    listed_id,
    input logic                          valid_res,
    input logic                          last
);

    import tloit_pkg::*;

    logic                 out_xfer;
    logic [COUNT_W:0]     total_now;
    logic [COUNT_W:0]     total_reg;
    logic                 walk_open_reg;

    assign out_xfer  = out_valid && !out_stall;
    assign total_now = (COUNT_W+1)'(attr_count) + (COUNT_W+1)'(style_count);

    // entry total and open-walk tracking over transferred results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            walk_open_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            total_reg     <= total_now;
            walk_open_reg <= valid_res && !last;
        end
    end

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot)
            && $stable(listed_id) && $stable(last))
        else $error("result changed while stalled");

    // only a created entry grows the total; moves keep it
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (total_now == total_reg + (COUNT_W+1)'(created)))
        else $error("list counts inconsistent with created");

    // a walk in progress continues with real entries only
    a_walk_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && walk_open_reg |-> valid_res && status == ST_OK)
        else $error("walk broken by a non-entry result");

    // one item at a time: intake closes after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

endmodule

bind two_list_ordered_id_table tloit_checker u_tloit_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the two-list ordered id table: directed rows, then random traffic.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tloit_pkg::*;

    localparam int ID_COUNT     = ID_COUNT_DEF;
    localparam int SLOT_TOTAL   = SENTINELS + ID_COUNT;
    localparam int RESET_CYCLES = 6;
    localparam int PER_PHASE    = 62;       // random transfers in each phase
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off in the last phase
    localparam int DRAIN_CYCLES = 24;       // extra wait after the last expected result, leave margin
    localparam int LIMIT_CYCLES = 400000;   // worst case: 64 ids per walk, heavy stalls

    localparam int SEND_GAP [3] = '{31, 47, 0};
    localparam int RECV_GAP [3] = '{47, 31, 0};

    // place codes that the block rejects
    localparam logic [1:0] PLACE_DELETED = 2'd2;
    localparam logic [1:0] PLACE_BAD     = 2'd3;

    localparam logic [SLOT_W-1:0] ABSENT = '1;

    // one result as it leaves the block
    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic                 created;
        logic                 moved;
        logic [COUNT_W-1:0]   attr_count;
        logic [COUNT_W-1:0]   style_count;
        logic [ID_W-1:0]      listed_id;
        logic                 valid_res;
        logic                 last;
    } result_t;

    // one input transfer; typed rows carry their expected result
    typedef struct packed {
        kind_t                kind;
        logic [ID_W-1:0]      id;
        logic [1:0]           place;
        logic                 typed;
        result_t              want;
    } stim_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 kind = 1'b0;
    logic [ID_W-1:0]      id = '0;
    logic [1:0]           place = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [SLOT_W-1:0]    slot;
    logic                 created;
    logic                 moved;
    logic [COUNT_W-1:0]   attr_count;
    logic [COUNT_W-1:0]   style_count;
    logic [ID_W-1:0]      listed_id;
    logic                 valid_res;
    logic                 last;

    int                   send_gap_pct = 0;
    int                   recv_gap_pct = 0;
    logic                 hold_armed = 1'b0;
    logic                 hold_done = 1'b0;
    int                   hold_left = 0;
    int                   cycle_count = 0;
    int                   mismatch_count = 0;

    // shadow copy of the table
    logic [SLOT_W-1:0]    slot_of_id [ID_COUNT];
    logic [SLOT_W-1:0]    next_of [SLOT_TOTAL];
    logic [SLOT_W-1:0]    prev_of [SLOT_TOTAL];
    logic                 place_of [SLOT_TOTAL];
    logic [ID_W-1:0]      key_of [SLOT_TOTAL];
    logic [SLOT_W-1:0]    next_free;
    logic [COUNT_W-1:0]   attr_n;
    logic [COUNT_W-1:0]   style_n;

    result_t              owed_results [$];
    stim_t                directed [$];

    two_list_ordered_id_table #(
        .ID_COUNT    (ID_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .id          (id),
        .place       (place),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot        (slot),
        .created     (created),
        .moved       (moved),
        .attr_count  (attr_count),
        .style_count (style_count),
        .listed_id   (listed_id),
        .valid_res   (valid_res),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    task automatic report_fail(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic field_check(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_fail($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // splice slot s in front of the tail sentinel of list pl
    task automatic link_tail(input logic [SLOT_W-1:0] s, input logic pl);
        logic [SLOT_W-1:0] tail_s;
        logic [SLOT_W-1:0] prior;
        tail_s = pl ? TAIL_STYLE : TAIL_ATTR;
        prior = prev_of[tail_s];
        place_of[s] = pl;
        prev_of[s] = prior;
        next_of[s] = tail_s;
        next_of[prior] = s;
        prev_of[tail_s] = s;
    endtask

    // Update the shadow table for one accepted transfer and queue what it should emit.
    task automatic advance_table(input stim_t s);
        logic [SLOT_W-1:0] at;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0] head_s;
        logic [SLOT_W-1:0] tail_s;
        logic              pl;
        result_t           r;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        pl = s.place[0];
        if (s.place > PLACE_STYLE)
        begin
            r.status = ST_BAD_PLACE;
        end
        else if (s.kind == KIND_PUT)
        begin
            if (s.id >= ID_COUNT)
            begin
                r.status = ST_BAD_ID;
            end
            else
            begin
                at = slot_of_id[s.id];
                if (at == ABSENT)
                begin
                    at = next_free;
                    next_free++;
                    slot_of_id[s.id] = at;
                    key_of[at] = s.id;
                    link_tail(at, pl);
                    if (pl)
                        style_n++;
                    else
                        attr_n++;
                    r.created = 1'b1;
                end
                else if (place_of[at] != pl)
                begin
                    next_of[prev_of[at]] = next_of[at];
                    prev_of[next_of[at]] = prev_of[at];
                    link_tail(at, pl);
                    if (pl)
                    begin
                        style_n++;
                        attr_n--;
                    end
                    else
                    begin
                        attr_n++;
                        style_n--;
                    end
                    r.moved = 1'b1;
                end
                r.slot = at;
            end
        end
        r.attr_count = attr_n;
        r.style_count = style_n;
        if (s.kind == KIND_WALK && s.place <= PLACE_STYLE)
        begin
            head_s = pl ? HEAD_STYLE : HEAD_ATTR;
            tail_s = pl ? TAIL_STYLE : TAIL_ATTR;
            cur = next_of[head_s];
            if (cur == tail_s)
                owed_results.push_back(r);
            while (cur != tail_s)
            begin
                nxt = next_of[cur];
                r.listed_id = key_of[cur];
                r.valid_res = 1'b1;
                r.last = (nxt == tail_s);
                owed_results.push_back(r);
                cur = nxt;
            end
        end
        else
        begin
            owed_results.push_back(r);
        end
        // typed rows all give a single result: swap in the hand-written one
        if (s.typed)
        begin
            void'(owed_results.pop_back());
            owed_results.push_back(s.want);
        end
    endtask

    task automatic add_row(input kind_t k, input int i, input logic [1:0] p,
                           input logic typed, input status_t st, input int sl,
                           input logic cr, input logic mv, input int ac, input int sc);
        stim_t s;
        s = '0;
        s.kind = k;
        s.id = ID_W'(i);
        s.place = p;
        s.typed = typed;
        s.want.status = st;
        s.want.slot = SLOT_W'(sl);
        s.want.created = cr;
        s.want.moved = mv;
        s.want.attr_count = COUNT_W'(ac);
        s.want.style_count = COUNT_W'(sc);
        s.want.last = 1'b1;
        directed.push_back(s);
    endtask

    // Offer one transfer after a random gap and wait for it to be taken.
    // valid stays high between back-to-back transfers; it only drops inside a gap.
    task automatic offer(input stim_t s);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= s.kind;
        id <= s.id;
        place <= s.place;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_table(s);
    endtask

    // Receiver: random stall, plus one long hold-off counted here once armed.
    always @(posedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Result checker: every transfer out is matched with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
            begin
                report_fail($sformatf("result with nothing expected, listed_id %0h",
                                      listed_id));
            end
            else
            begin
                want = owed_results.pop_front();
                field_check("status", 8'(status), 8'(want.status));
                field_check("slot", 8'(slot), 8'(want.slot));
                field_check("created", 8'(created), 8'(want.created));
                field_check("moved", 8'(moved), 8'(want.moved));
                field_check("attr_count", 8'(attr_count), 8'(want.attr_count));
                field_check("style_count", 8'(style_count), 8'(want.style_count));
                field_check("listed_id", listed_id, want.listed_id);
                field_check("valid_res", 8'(valid_res), 8'(want.valid_res));
                field_check("last", 8'(last), 8'(want.last));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        stim_t s;
        int    roll;

        // shadow table starts as the block does after reset
        for (int i = 0; i < ID_COUNT; i++)
            slot_of_id[i] = ABSENT;
        for (int i = 0; i < SLOT_TOTAL; i++)
        begin
            next_of[i] = '0;
            prev_of[i] = '0;
            place_of[i] = 1'b0;
            key_of[i] = '0;
        end
        prev_of[HEAD_ATTR] = HEAD_ATTR;
        next_of[HEAD_ATTR] = TAIL_ATTR;
        prev_of[TAIL_ATTR] = HEAD_ATTR;
        next_of[TAIL_ATTR] = TAIL_ATTR;
        prev_of[HEAD_STYLE] = HEAD_STYLE;
        next_of[HEAD_STYLE] = TAIL_STYLE;
        prev_of[TAIL_STYLE] = HEAD_STYLE;
        next_of[TAIL_STYLE] = TAIL_STYLE;
        next_free = FIRST_ENTRY;
        attr_n = '0;
        style_n = '0;

        // Directed rows. Typed rows: empty lists, rejections, the first allocations, a same-list repeat.
        //       kind       id   place          typed st            slot cr mv  ac sc
        add_row(KIND_WALK,   0, PLACE_ATTR,    1'b1, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_WALK,   0, PLACE_STYLE,   1'b1, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_WALK,   0, PLACE_DELETED, 1'b1, ST_BAD_PLACE, 0, 0, 0, 0, 0);
        add_row(KIND_PUT,    0, PLACE_BAD,     1'b1, ST_BAD_PLACE, 0, 0, 0, 0, 0);
        add_row(KIND_PUT,  255, PLACE_ATTR,    1'b1, ST_BAD_ID,    0, 0, 0, 0, 0);
        add_row(KIND_PUT,   64, PLACE_STYLE,   1'b1, ST_BAD_ID,    0, 0, 0, 0, 0);
        // place is checked before the id is looked up or allocated
        add_row(KIND_PUT,   63, PLACE_DELETED, 1'b1, ST_BAD_PLACE, 0, 0, 0, 0, 0);
        add_row(KIND_PUT,    0, PLACE_ATTR,    1'b1, ST_OK,        4, 1, 0, 1, 0);
        add_row(KIND_PUT,   63, PLACE_STYLE,   1'b1, ST_OK,        5, 1, 0, 1, 1);
        // same list again: no change
        add_row(KIND_PUT,    0, PLACE_ATTR,    1'b1, ST_OK,        4, 0, 0, 1, 1);
        add_row(KIND_PUT,    7, PLACE_ATTR,    1'b0, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_PUT,   33, PLACE_ATTR,    1'b0, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_WALK,   0, PLACE_ATTR,    1'b0, ST_OK,        0, 0, 0, 0, 0);
        // moves from the middle, the head and the last remaining entry
        add_row(KIND_PUT,    7, PLACE_STYLE,   1'b0, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_PUT,    0, PLACE_STYLE,   1'b0, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_PUT,   33, PLACE_STYLE,   1'b0, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_WALK,   0, PLACE_ATTR,    1'b1, ST_OK,        0, 0, 0, 0, 4);
        add_row(KIND_WALK,   0, PLACE_STYLE,   1'b0, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_PUT,   63, PLACE_ATTR,    1'b0, ST_OK,        0, 0, 0, 0, 0);
        // walk ignores the id
        add_row(KIND_WALK, 255, PLACE_STYLE,   1'b0, ST_OK,        0, 0, 0, 0, 0);
        add_row(KIND_WALK, 170, PLACE_BAD,     1'b1, ST_BAD_PLACE, 0, 0, 0, 1, 3);
        add_row(KIND_PUT,  128, PLACE_BAD,     1'b1, ST_BAD_PLACE, 0, 0, 0, 1, 3);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = SEND_GAP[0];
        recv_gap_pct = RECV_GAP[0];
        foreach (directed[i])
            offer(directed[i]);

        // Random traffic: mostly legal puts over a skewed id pool so that
        // entries move back and forth, some walks, a few rejects.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap_pct = SEND_GAP[ph];
            recv_gap_pct = RECV_GAP[ph];
            // no idling in the last phase: hold the receiver off so the block backs up
            if (ph == 2)
                hold_armed <= 1'b1;
            repeat (PER_PHASE)
            begin
                s = '0;
                s.kind = ($urandom_range(99) < 15) ? KIND_WALK : KIND_PUT;
                roll = $urandom_range(99);
                if (roll < 45)
                    s.place = PLACE_ATTR;
                else if (roll < 90)
                    s.place = PLACE_STYLE;
                else if (roll < 95)
                    s.place = PLACE_DELETED;
                else
                    s.place = PLACE_BAD;
                roll = $urandom_range(99);
                if (roll < 40)
                    s.id = ID_W'($urandom_range(15));
                else if (roll < 85)
                    s.id = ID_W'($urandom_range(ID_COUNT - 1));
                else
                    s.id = ID_W'($urandom_range(255, ID_COUNT));
                offer(s);
            end
        end
        in_valid <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/tloit_pkg.sv
hdl/tloit_ram.sv
hdl/two_list_ordered_id_table.sv
hdl/tloit_checker.sv
bench/testbench.sv
